// ===== rtl/group_favoring_lock_arbiter_macros.svh =====
// Assertion macros shared by the lock arbiter modules.
`ifndef GROUP_FAVORING_LOCK_ARBITER_MACROS_SVH
`define GROUP_FAVORING_LOCK_ARBITER_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property on a given clock, held off while reset is asserted.
`define GFLA_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checks a property on the module's own clk_i and rst_ni.
`define GFLA_ASSERT(lbl, prop, msg) \
  `GFLA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define GFLA_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define GFLA_ASSERT(lbl, prop, msg)
`endif
`endif

// ===== rtl/gfla_pkg.sv =====
package gfla_pkg;

  // Sizing of the lock bank and of each waiter queue.
  localparam int unsigned NUM_LOCKS   = 15;
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned LKW     = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int unsigned CNTW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MEM_DEPTH = NUM_LOCKS * QUEUE_DEPTH;
  localparam int unsigned ADDR_W  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Field widths of the request and result.
  localparam int unsigned LOCK_ID_W = 4;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned GRP_W     = 8;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned WAITER_W  = ID_W + GRP_W;

  typedef enum logic [1:0] {
    FN_CREATE  = 2'd0,
    FN_ACQUIRE = 2'd1,
    FN_RELEASE = 2'd2,
    FN_DESTROY = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_ID    = 3'd1,
    ST_INACTIVE  = 3'd2,
    ST_NOT_OWNER = 3'd3,
    ST_FULL      = 3'd4,
    ST_NO_FREE   = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_PICK_RD,
    S_PICK_CAP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_HAND,
    S_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic idx_clr;
    logic idx_inc;
    logic rd_next;
    logic cap_pick;
    logic cap_fav;
    logic wr_shift;
    logic commit_simple;
    logic commit_hand;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_hand;
    logic search_en;
    logic match;
    logic last;
    logic out_free;
  } sts_t;

  // Waiter memory address of one queue position of one lock.
  function automatic logic [ADDR_W-1:0] q_addr(input logic [LKW-1:0] lk,
                                               input logic [CNTW-1:0] pos);
    q_addr = ADDR_W'(lk) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(pos);
  endfunction

endpackage

// ===== rtl/gfla_ram.sv =====
module gfla_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/gfla_ctrl.sv =====
`include "group_favoring_lock_arbiter_macros.svh"

module gfla_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  gfla_pkg::sts_t  sts_i,
  output gfla_pkg::cmd_t  cmd_o
);

  gfla_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gfla_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gfla_pkg::S_IDLE: begin
        if (in_valid_i) state_d = gfla_pkg::S_DECODE;
      end
      gfla_pkg::S_DECODE: begin
        if (!sts_i.need_hand) state_d = gfla_pkg::S_DONE;
        else if (sts_i.search_en) state_d = gfla_pkg::S_SRCH_RD;
        else state_d = gfla_pkg::S_PICK_RD;
      end
      gfla_pkg::S_SRCH_RD: state_d = gfla_pkg::S_SRCH_CMP;
      gfla_pkg::S_SRCH_CMP: begin
        if (sts_i.match) state_d = gfla_pkg::S_SHIFT_RD;
        else if (sts_i.last) state_d = gfla_pkg::S_PICK_RD;
        else state_d = gfla_pkg::S_SRCH_RD;
      end
      gfla_pkg::S_PICK_RD:  state_d = gfla_pkg::S_PICK_CAP;
      gfla_pkg::S_PICK_CAP: state_d = gfla_pkg::S_SHIFT_RD;
      gfla_pkg::S_SHIFT_RD: begin
        state_d = sts_i.last ? gfla_pkg::S_HAND : gfla_pkg::S_SHIFT_WR;
      end
      gfla_pkg::S_SHIFT_WR: state_d = gfla_pkg::S_SHIFT_RD;
      gfla_pkg::S_HAND:     state_d = gfla_pkg::S_DONE;
      gfla_pkg::S_DONE: begin
        if (sts_i.out_free) state_d = gfla_pkg::S_IDLE;
      end
      default: state_d = gfla_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      gfla_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      gfla_pkg::S_DECODE: begin
        cmd_o.idx_clr       = 1'b1;
        cmd_o.commit_simple = !sts_i.need_hand;
      end
      gfla_pkg::S_SRCH_RD: ;
      gfla_pkg::S_SRCH_CMP: begin
        if (sts_i.match) begin
          cmd_o.cap_pick = 1'b1;
          cmd_o.cap_fav  = 1'b1;
        end else if (sts_i.last) begin
          cmd_o.idx_clr = 1'b1;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      gfla_pkg::S_PICK_RD: ;
      gfla_pkg::S_PICK_CAP: cmd_o.cap_pick = 1'b1;
      gfla_pkg::S_SHIFT_RD: cmd_o.rd_next = !sts_i.last;
      gfla_pkg::S_SHIFT_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
      end
      gfla_pkg::S_HAND: cmd_o.commit_hand = 1'b1;
      gfla_pkg::S_DONE: cmd_o.load_out = sts_i.out_free;
      default: ;
    endcase
  end

  `GFLA_ASSERT(a_srch_cmp_follows, state_q == gfla_pkg::S_SRCH_RD |=> state_q == gfla_pkg::S_SRCH_CMP, "search read not followed by compare")
  `GFLA_ASSERT(a_hand_to_done, cmd_o.commit_hand |=> state_q == gfla_pkg::S_DONE, "hand-off commit not followed by done")

endmodule

// ===== rtl/gfla_dpath.sv =====
`include "group_favoring_lock_arbiter_macros.svh"

module gfla_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gfla_pkg::cmd_t                    cmd_i,
  output gfla_pkg::sts_t                    sts_o,
  input  logic [1:0]                        func_i,
  input  logic [gfla_pkg::LOCK_ID_W-1:0]    lock_id_i,
  input  logic [gfla_pkg::ID_W-1:0]         requester_id_i,
  input  logic [gfla_pkg::GRP_W-1:0]        requester_group_i,
  input  logic [gfla_pkg::PCT_W-1:0]        favor_percent_i,
  input  logic [gfla_pkg::PCT_W-1:0]        rand_value_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [gfla_pkg::STATUS_W-1:0]     status_o,
  output logic [gfla_pkg::LOCK_ID_W-1:0]    created_lock_o,
  output logic                              granted_o,
  output logic                              handed_over_o,
  output logic                              favored_o,
  output logic [gfla_pkg::ID_W-1:0]         new_owner_id_o,
  output logic [gfla_pkg::GRP_W-1:0]        new_owner_group_o
);

  // Latched request.
  gfla_pkg::func_e                    func_q;
  logic [gfla_pkg::LOCK_ID_W-1:0]     lock_id_q;
  logic [gfla_pkg::ID_W-1:0]          rid_q;
  logic [gfla_pkg::GRP_W-1:0]         rgrp_q;
  logic [gfla_pkg::PCT_W-1:0]         favor_in_q;
  logic [gfla_pkg::PCT_W-1:0]         rnd_q;

  // Per-lock state.
  logic [gfla_pkg::NUM_LOCKS-1:0]     active_q;
  logic [gfla_pkg::PCT_W-1:0]         favor_q     [gfla_pkg::NUM_LOCKS];
  logic [gfla_pkg::ID_W-1:0]          owner_id_q  [gfla_pkg::NUM_LOCKS];
  logic [gfla_pkg::GRP_W-1:0]         owner_grp_q [gfla_pkg::NUM_LOCKS];
  logic                               owner_gv_q  [gfla_pkg::NUM_LOCKS];
  logic [gfla_pkg::CNTW-1:0]          cnt_q       [gfla_pkg::NUM_LOCKS];

  // Queue walk and chosen waiter.
  logic [gfla_pkg::CNTW-1:0]          idx_q;
  logic [gfla_pkg::ID_W-1:0]          pick_id_q;
  logic [gfla_pkg::GRP_W-1:0]         pick_grp_q;
  logic                               fav_q;

  // Pending result and output register.
  gfla_pkg::status_e                  res_status_q;
  logic [gfla_pkg::LOCK_ID_W-1:0]     res_created_q;
  logic                               res_granted_q;
  logic                               res_handed_q;
  logic                               res_favored_q;
  logic [gfla_pkg::ID_W-1:0]          res_id_q;
  logic [gfla_pkg::GRP_W-1:0]         res_grp_q;
  logic                               out_valid_q;
  gfla_pkg::status_e                  out_status_q;
  logic [gfla_pkg::LOCK_ID_W-1:0]     out_created_q;
  logic                               out_granted_q;
  logic                               out_handed_q;
  logic                               out_favored_q;
  logic [gfla_pkg::ID_W-1:0]          out_id_q;
  logic [gfla_pkg::GRP_W-1:0]         out_grp_q;

  logic [gfla_pkg::LKW-1:0]           lk;
  logic                               lk_ok;
  logic                               cur_active;
  logic [gfla_pkg::CNTW-1:0]          cur_cnt;
  logic                               free_found;
  logic [gfla_pkg::LKW-1:0]           free_idx;
  logic                               acq_grant;
  logic                               acq_full;
  logic                               enq;
  logic                               ram_we;
  logic [gfla_pkg::ADDR_W-1:0]        ram_waddr;
  logic [gfla_pkg::ADDR_W-1:0]        ram_raddr;
  logic [gfla_pkg::WAITER_W-1:0]      ram_wdata;
  logic [gfla_pkg::WAITER_W-1:0]      ram_rdata;
  logic [gfla_pkg::CNTW-1:0]          idx_next;

  // Addressed lock and its current state.
  assign lk         = gfla_pkg::LKW'(lock_id_q);
  assign lk_ok      = int'(lock_id_q) < gfla_pkg::NUM_LOCKS;
  assign cur_active = lk_ok && active_q[lk];
  assign cur_cnt    = cnt_q[lk];
  assign idx_next   = idx_q + gfla_pkg::CNTW'(1);

  // Lowest inactive lock for create.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = gfla_pkg::NUM_LOCKS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found = 1'b1;
        free_idx   = gfla_pkg::LKW'(i);
      end
    end
  end

  // Acquire outcome.
  assign acq_grant = (owner_id_q[lk] == '0) && (cur_cnt == '0);
  assign acq_full  = cur_cnt >= gfla_pkg::CNTW'(gfla_pkg::QUEUE_DEPTH);
  assign enq = cmd_i.commit_simple && (func_q == gfla_pkg::FN_ACQUIRE) && cur_active &&
               !acq_grant && !acq_full;

  // Status toward the controller.
  always_comb begin
    sts_o.need_hand = (func_q == gfla_pkg::FN_RELEASE) && cur_active &&
                      (owner_id_q[lk] == rid_q) && (cur_cnt != '0);
    sts_o.search_en = owner_gv_q[lk] && (rnd_q < favor_q[lk]);
    sts_o.match     = ram_rdata[gfla_pkg::GRP_W-1:0] == owner_grp_q[lk];
    sts_o.last      = idx_next >= cur_cnt;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // Waiter memory ports: enqueue or shift on write, walk on read.
  assign ram_we    = enq || cmd_i.wr_shift;
  assign ram_waddr = enq ? gfla_pkg::q_addr(lk, cur_cnt) : gfla_pkg::q_addr(lk, idx_q);
  assign ram_wdata = enq ? {rid_q, rgrp_q} : ram_rdata;
  assign ram_raddr = gfla_pkg::q_addr(lk, cmd_i.rd_next ? idx_next : idx_q);

  gfla_ram #(
    .WIDTH (gfla_pkg::WAITER_W),
    .DEPTH (gfla_pkg::MEM_DEPTH)
  ) u_waiters (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Active flags, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cmd_i.commit_simple) begin
      if (func_q == gfla_pkg::FN_CREATE && free_found) begin
        active_q[free_idx] <= 1'b1;
      end else if (func_q == gfla_pkg::FN_DESTROY && cur_active) begin
        active_q[lk] <= 1'b0;
      end
    end
  end

  // Request latch, queue walk and chosen waiter.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q     <= gfla_pkg::func_e'(func_i);
      lock_id_q  <= lock_id_i;
      rid_q      <= requester_id_i;
      rgrp_q     <= requester_group_i;
      favor_in_q <= favor_percent_i;
      rnd_q      <= rand_value_i;
    end
    if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_next;
    end
    if (cmd_i.cap_pick) begin
      pick_id_q  <= ram_rdata[gfla_pkg::WAITER_W-1:gfla_pkg::GRP_W];
      pick_grp_q <= ram_rdata[gfla_pkg::GRP_W-1:0];
      fav_q      <= cmd_i.cap_fav;
    end
  end

  // Per-lock payload updates and the pending result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_simple) begin
      res_status_q  <= gfla_pkg::ST_OK;
      res_created_q <= '0;
      res_granted_q <= 1'b0;
      res_handed_q  <= 1'b0;
      res_favored_q <= 1'b0;
      res_id_q      <= '0;
      res_grp_q     <= '0;
      if (func_q == gfla_pkg::FN_CREATE) begin
        if (free_found) begin
          favor_q[free_idx]     <= favor_in_q;
          owner_id_q[free_idx]  <= '0;
          owner_grp_q[free_idx] <= '0;
          owner_gv_q[free_idx]  <= 1'b0;
          cnt_q[free_idx]       <= '0;
          res_created_q         <= gfla_pkg::LOCK_ID_W'(free_idx);
        end else begin
          res_status_q <= gfla_pkg::ST_NO_FREE;
        end
      end else if (!lk_ok) begin
        res_status_q <= gfla_pkg::ST_BAD_ID;
      end else if (!cur_active) begin
        res_status_q <= gfla_pkg::ST_INACTIVE;
      end else begin
        unique case (func_q)
          gfla_pkg::FN_ACQUIRE: begin
            if (acq_grant) begin
              owner_id_q[lk]  <= rid_q;
              owner_grp_q[lk] <= rgrp_q;
              owner_gv_q[lk]  <= 1'b1;
              res_granted_q   <= 1'b1;
            end else if (acq_full) begin
              res_status_q <= gfla_pkg::ST_FULL;
            end else begin
              cnt_q[lk] <= cur_cnt + gfla_pkg::CNTW'(1);
            end
          end
          gfla_pkg::FN_RELEASE: begin
            // Only the no-waiter case reaches here on success.
            if (owner_id_q[lk] != rid_q) begin
              res_status_q <= gfla_pkg::ST_NOT_OWNER;
            end else begin
              owner_id_q[lk]  <= '0;
              owner_grp_q[lk] <= '0;
              owner_gv_q[lk]  <= 1'b0;
            end
          end
          gfla_pkg::FN_CREATE, gfla_pkg::FN_DESTROY: ;
          default: ;
        endcase
      end
    end else if (cmd_i.commit_hand) begin
      owner_id_q[lk]  <= pick_id_q;
      owner_grp_q[lk] <= pick_grp_q;
      owner_gv_q[lk]  <= 1'b1;
      cnt_q[lk]       <= cur_cnt - gfla_pkg::CNTW'(1);
      res_status_q    <= gfla_pkg::ST_OK;
      res_created_q   <= '0;
      res_granted_q   <= 1'b0;
      res_handed_q    <= 1'b1;
      res_favored_q   <= fav_q;
      res_id_q        <= pick_id_q;
      res_grp_q       <= pick_grp_q;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q  <= res_status_q;
      out_created_q <= res_created_q;
      out_granted_q <= res_granted_q;
      out_handed_q  <= res_handed_q;
      out_favored_q <= res_favored_q;
      out_id_q      <= res_id_q;
      out_grp_q     <= res_grp_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign created_lock_o    = out_created_q;
  assign granted_o         = out_granted_q;
  assign handed_over_o     = out_handed_q;
  assign favored_o         = out_favored_q;
  assign new_owner_id_o    = out_id_q;
  assign new_owner_group_o = out_grp_q;

  `GFLA_ASSERT(a_shift_in_queue, cmd_i.wr_shift |-> idx_next < cur_cnt, "shift beyond queue end")
  `GFLA_ASSERT(a_hand_has_waiter, cmd_i.commit_hand |-> cur_cnt != '0, "hand-off with empty queue")
  `GFLA_ASSERT(a_no_overwrite, cmd_i.load_out |-> (!out_valid_q || out_ready_i), "result overwritten")

endmodule

// ===== rtl/group_favoring_lock_arbiter.sv =====
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    func, lock_id, requester_id/group, favor, rand
// out      out_valid_o / out_ready_i  status, created_lock, granted, handed_over,
//                                     favored, new_owner_id, new_owner_group
//
// One request at a time. Create, acquire, destroy and a release without waiters
// commit their result from the decode step. A release that hands off searches the
// queue for the owner's group when the roll is below its favor, else or on no match
// takes the head, then shifts later waiters up through the single memory read port.
// Reset clears the active flags, the sequencer and the result valid flag.
// A new request is taken while the previous result waits in the output register.
module group_favoring_lock_arbiter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        func_i,
  input  logic [gfla_pkg::LOCK_ID_W-1:0]    lock_id_i,
  input  logic [gfla_pkg::ID_W-1:0]         requester_id_i,
  input  logic [gfla_pkg::GRP_W-1:0]        requester_group_i,
  input  logic [gfla_pkg::PCT_W-1:0]        favor_percent_i,
  input  logic [gfla_pkg::PCT_W-1:0]        rand_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gfla_pkg::STATUS_W-1:0]     status_o,
  output logic [gfla_pkg::LOCK_ID_W-1:0]    created_lock_o,
  output logic                              granted_o,
  output logic                              handed_over_o,
  output logic                              favored_o,
  output logic [gfla_pkg::ID_W-1:0]         new_owner_id_o,
  output logic [gfla_pkg::GRP_W-1:0]        new_owner_group_o
);

  gfla_pkg::cmd_t cmd;
  gfla_pkg::sts_t sts;

  // Sequencer for each request.
  gfla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Lock state, waiter memory and result registers.
  gfla_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .func_i            (func_i),
    .lock_id_i         (lock_id_i),
    .requester_id_i    (requester_id_i),
    .requester_group_i (requester_group_i),
    .favor_percent_i   (favor_percent_i),
    .rand_value_i      (rand_value_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .status_o          (status_o),
    .created_lock_o    (created_lock_o),
    .granted_o         (granted_o),
    .handed_over_o     (handed_over_o),
    .favored_o         (favored_o),
    .new_owner_id_o    (new_owner_id_o),
    .new_owner_group_o (new_owner_group_o)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import gfla_pkg::*;

  localparam int unsigned WDOG_LIMIT = 20000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [1:0] func_i;
  logic [LOCK_ID_W-1:0] lock_id_i;
  logic [ID_W-1:0] requester_id_i;
  logic [GRP_W-1:0] requester_group_i;
  logic [PCT_W-1:0] favor_percent_i;
  logic [PCT_W-1:0] rand_value_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [STATUS_W-1:0] status_o;
  logic [LOCK_ID_W-1:0] created_lock_o;
  logic granted_o;
  logic handed_over_o;
  logic favored_o;
  logic [ID_W-1:0] new_owner_id_o;
  logic [GRP_W-1:0] new_owner_group_o;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LOCK_ID_W-1:0] created;
    logic granted;
    logic handed;
    logic favored;
    logic [ID_W-1:0] owner_id;
    logic [GRP_W-1:0] owner_grp;
  } lock_result_t;

  group_favoring_lock_arbiter u_dut (.*);

  // Shadow copy of the lock bank.
  logic                active_q [NUM_LOCKS];
  logic [PCT_W-1:0]    favor_q  [NUM_LOCKS];
  logic [ID_W-1:0]     own_id_q [NUM_LOCKS];
  logic [GRP_W-1:0]    own_grp_q[NUM_LOCKS];
  logic                own_gv_q [NUM_LOCKS];
  logic [ID_W-1:0]     wait_id_q [NUM_LOCKS][$];
  logic [GRP_W-1:0]    wait_grp_q[NUM_LOCKS][$];

  lock_result_t pending_results[$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  idle_cycles = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_handoffs = 0;
  int  n_favored = 0;

  // Predicts the result of one request and updates the shadow bank.
  function automatic lock_result_t predict_lock_op(input func_e fn, input int lk,
      input logic [ID_W-1:0] rid, input logic [GRP_W-1:0] rgrp,
      input logic [PCT_W-1:0] fav, input logic [PCT_W-1:0] rnd);
    lock_result_t r;
    int pick;
    bit found;
    r = '0;
    if (fn == FN_CREATE) begin
      r.status = ST_NO_FREE;
      for (int i = 0; i < NUM_LOCKS; i++) begin
        if (!active_q[i]) begin
          active_q[i] = 1'b1;
          favor_q[i] = fav;
          own_id_q[i] = '0;
          own_grp_q[i] = '0;
          own_gv_q[i] = 1'b0;
          wait_id_q[i].delete();
          wait_grp_q[i].delete();
          r.status = ST_OK;
          r.created = LOCK_ID_W'(i);
          break;
        end
      end
    end else if (lk >= NUM_LOCKS) begin
      r.status = ST_BAD_ID;
    end else if (!active_q[lk]) begin
      r.status = ST_INACTIVE;
    end else if (fn == FN_ACQUIRE) begin
      if (own_id_q[lk] == 0 && wait_id_q[lk].size() == 0) begin
        own_id_q[lk] = rid;
        own_grp_q[lk] = rgrp;
        own_gv_q[lk] = 1'b1;
        r.granted = 1'b1;
      end else if (wait_id_q[lk].size() >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        wait_id_q[lk].push_back(rid);
        wait_grp_q[lk].push_back(rgrp);
      end
    end else if (fn == FN_RELEASE) begin
      if (own_id_q[lk] != rid) begin
        r.status = ST_NOT_OWNER;
      end else if (wait_id_q[lk].size() == 0) begin
        own_id_q[lk] = '0;
        own_grp_q[lk] = '0;
        own_gv_q[lk] = 1'b0;
      end else begin
        pick = 0;
        found = 0;
        if (own_gv_q[lk]) begin
          for (int i = 0; i < wait_grp_q[lk].size(); i++) begin
            if (wait_grp_q[lk][i] == own_grp_q[lk]) begin
              pick = i;
              found = 1;
              break;
            end
          end
        end
        if (found && rnd < favor_q[lk]) r.favored = 1'b1;
        else pick = 0;
        own_id_q[lk] = wait_id_q[lk][pick];
        own_grp_q[lk] = wait_grp_q[lk][pick];
        own_gv_q[lk] = 1'b1;
        wait_id_q[lk].delete(pick);
        wait_grp_q[lk].delete(pick);
        r.handed = 1'b1;
        r.owner_id = own_id_q[lk];
        r.owner_grp = own_grp_q[lk];
      end
    end else begin
      active_q[lk] = 1'b0;
    end
    return r;
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sends one request and records its expected result on acceptance.
  // Valid stays high after acceptance so that requests can follow back to back.
  task automatic send_request(input func_e fn, input int lk, input int rid,
      input int rgrp, input int fav, input int rnd);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= fn;
    lock_id_i <= LOCK_ID_W'(lk);
    requester_id_i <= ID_W'(rid);
    requester_group_i <= GRP_W'(rgrp);
    favor_percent_i <= PCT_W'(fav);
    rand_value_i <= PCT_W'(rnd);
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_lock_op(fn, lk, ID_W'(rid), GRP_W'(rgrp),
                                              PCT_W'(fav), PCT_W'(rnd)));
    n_sent++;
  endtask

  // Stops sending and waits until every expected result has come.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver readiness, drawn each cycle.
  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker.
  always @(posedge clk_i) begin
    lock_result_t exp_r;
    lock_result_t act_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      act_r = '{status_o, created_lock_o, granted_o, handed_over_o, favored_o,
                new_owner_id_o, new_owner_group_o};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, act_r);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        n_checked++;
        if (act_r.handed) n_handoffs++;
        if (act_r.favored) n_favored++;
        if (act_r.status != exp_r.status)
          $display("%0t: status exp %0d got %0d", $time, exp_r.status, act_r.status);
        if (act_r.created != exp_r.created)
          $display("%0t: created_lock exp %0d got %0d", $time, exp_r.created, act_r.created);
        if (act_r.granted != exp_r.granted)
          $display("%0t: granted exp %0d got %0d", $time, exp_r.granted, act_r.granted);
        if (act_r.handed != exp_r.handed)
          $display("%0t: handed_over exp %0d got %0d", $time, exp_r.handed, act_r.handed);
        if (act_r.favored != exp_r.favored)
          $display("%0t: favored exp %0d got %0d", $time, exp_r.favored, act_r.favored);
        if (act_r.owner_id != exp_r.owner_id)
          $display("%0t: new_owner_id exp %h got %h", $time, exp_r.owner_id,
                   act_r.owner_id);
        if (act_r.owner_grp != exp_r.owner_grp)
          $display("%0t: new_owner_group exp %h got %h", $time, exp_r.owner_grp,
                   act_r.owner_grp);
        if (act_r != exp_r) errors++;
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else if (pending_results.size() != 0 || in_valid_i) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Directed checks of every operation and of every error path but a full queue.
  task automatic test_directed();
    send_request(FN_ACQUIRE, 0, 1, 0, 0, 0);            // inactive lock
    send_request(FN_RELEASE, 15, 1, 0, 0, 0);           // id out of range
    send_request(FN_DESTROY, 15, 1, 0, 0, 0);
    send_request(FN_CREATE, 0, 1, 0, 100, 0);           // lock 0, favors every roll below 100
    send_request(FN_ACQUIRE, 0, 16'hFFFF, 8'hFF, 0, 0); // immediate grant
    send_request(FN_ACQUIRE, 0, 7, 1, 0, 0);
    send_request(FN_ACQUIRE, 0, 8, 8'hFF, 0, 0);
    send_request(FN_ACQUIRE, 0, 16'hFFFF, 8'hFF, 0, 0); // owner queues again
    send_request(FN_RELEASE, 0, 9, 0, 0, 0);            // not the owner
    send_request(FN_RELEASE, 0, 16'hFFFF, 0, 0, 99);    // favors a waiter behind the head
    send_request(FN_RELEASE, 0, 8, 0, 0, 127);          // off-range roll never favors
    send_request(FN_RELEASE, 0, 7, 0, 0, 0);            // no same-group waiter
    send_request(FN_ACQUIRE, 0, 8, 8'hFF, 0, 0);
    send_request(FN_RELEASE, 0, 16'hFFFF, 0, 0, 99);    // favored choice at the head
    send_request(FN_RELEASE, 0, 8, 0, 0, 0);            // frees the lock
    send_request(FN_ACQUIRE, 0, 4, 3, 0, 0);
    send_request(FN_ACQUIRE, 0, 0, 3, 0, 0);            // reserved id queues
    send_request(FN_ACQUIRE, 0, 5, 3, 0, 0);
    send_request(FN_RELEASE, 0, 4, 0, 0, 0);            // reserved id takes over
    send_request(FN_ACQUIRE, 0, 6, 3, 0, 0);            // free lock with a waiter
    send_request(FN_RELEASE, 0, 0, 0, 0, 0);            // id 0 counts as owner
    send_request(FN_CREATE, 0, 1, 0, 0, 0);             // lock 1, never favors
    send_request(FN_DESTROY, 0, 1, 0, 0, 0);
    send_request(FN_CREATE, 0, 1, 0, 127, 0);           // reuses lock 0
    for (int i = 0; i < 14; i++) send_request(FN_CREATE, 0, 1, 0, 50, 0);
    wait_drained();
  endtask

  // Fills one queue past its depth.
  task automatic test_queue_full();
    send_request(FN_ACQUIRE, 2, 100, 4, 0, 0);
    for (int i = 0; i <= QUEUE_DEPTH; i++) send_request(FN_ACQUIRE, 2, 200 + i, i % 3, 0, 0);
    for (int i = 0; i <= QUEUE_DEPTH; i++)
      send_request(FN_RELEASE, 2, own_id_q[2], 0, 0, $urandom_range(99));
    wait_drained();
  endtask

  // Mostly well-formed traffic on a few locks, with some noise.
  task automatic test_random(input int count);
    int lk;
    int pct;
    func_e fn;
    for (int n = 0; n < count; n++) begin
      lk = $urandom_range(3);
      pct = $urandom_range(99);
      if (pct < 3) begin
        send_request(FN_CREATE, $urandom_range(15), $urandom, $urandom, $urandom_range(127),
                     $urandom_range(127));
      end else if (pct < 6) begin
        send_request(FN_DESTROY, $urandom_range(15), $urandom, $urandom, 0, 0);
      end else if (pct < 10) begin
        fn = func_e'($urandom_range(3));
        if (fn == FN_CREATE) fn = FN_ACQUIRE;
        send_request(fn, $urandom_range(15), $urandom, $urandom, $urandom,
                     $urandom_range(127));
      end else if (pct < 55) begin
        send_request(FN_ACQUIRE, lk, $urandom_range(16'hFFFF, 1), $urandom_range(3) == 0 ?
                     $urandom : $urandom_range(2), $urandom, $urandom);
      end else begin
        send_request(FN_RELEASE, lk, $urandom_range(9) == 0 ? $urandom : own_id_q[lk],
                     $urandom, $urandom, $urandom_range(3) == 0 ? $urandom_range(127) :
                     $urandom_range(99));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    func_i = '0;
    lock_id_i = '0;
    requester_id_i = '0;
    requester_group_i = '0;
    favor_percent_i = '0;
    rand_value_i = '0;
    for (int i = 0; i < NUM_LOCKS; i++) begin
      active_q[i] = 1'b0;
      own_id_q[i] = '0;
      own_grp_q[i] = '0;
      own_gv_q[i] = 1'b0;
      favor_q[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 26;
    recv_idle_pct = 78;
    test_directed();
    test_queue_full();
    test_random(600);
    // Hold off until the block has drained.
    wait_drained();
    send_idle_pct = 78;
    recv_idle_pct = 26;
    test_random(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(600);

    wait_drained();
    repeat (100) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d results, %0d hand-offs, %0d favored.",
             n_sent, n_checked, n_handoffs, n_favored);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
